// ----- src/occ_pkg.sv -----
// Shared types and constants for the oven cook controller.
// Holds the item structs, the phase codes and the controller state record.
// No dependencies.
package occ_pkg;

  // Phase codes, as they appear on the result channel.
  typedef enum logic [3:0] {
    PH_SELECT   = 4'd0,
    PH_POWER    = 4'd1,
    PH_SETTIME  = 4'd2,
    PH_RUN      = 4'd3,
    PH_PAUSE    = 4'd4,
    PH_COMPLETE = 4'd5,
    PH_SETTEMP  = 4'd6,
    PH_PREHEAT  = 4'd7,
    PH_DONE     = 4'd8
  } phase_e;

  // Cooking modes.
  localparam logic [2:0] MODE_MICRO = 3'd1;
  localparam logic [2:0] MODE_CONV  = 3'd3;
  localparam logic [2:0] MODE_QUICK = 3'd4;

  // Keypad codes with a special meaning.
  localparam logic [3:0] KEY_ZERO = 4'd0;
  localparam logic [3:0] KEY_NINE = 4'd9;
  localparam logic [3:0] KEY_STAR = 4'd10;
  localparam logic [3:0] KEY_HASH = 4'd11;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PREHEAT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_QUICK   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUZZ    = 2'd2;
  localparam int unsigned CfgDataW = 7;

  // Reset values and limits.
  localparam logic [6:0] PREHEAT_RESET = 7'd60;
  localparam logic [5:0] QUICK_RESET   = 6'd30;
  localparam logic [3:0] BUZZ_RESET    = 4'd5;
  localparam logic [6:0] PREHEAT_MAX   = 7'd99;
  localparam logic [6:0] SECONDS_WRAP  = 7'd59;

  // Cleared temperature entry: digits 0 and 1 are zero and digit 2 is one.
  // Digit 2 sits in the upper nibble of the packed array.
  localparam logic [2:0][3:0] TEMP_CLEARED = {4'd1, 4'd0, 4'd0};

  typedef struct packed {
    logic       command;
    logic [3:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  cook_mode;
    logic [6:0]  minutes_left;
    logic [6:0]  seconds_left;
    logic [6:0]  preheat_left;
    logic        heater_on;
    logic        buzzer_on;
    logic [9:0]  temp_setting;
    logic [15:0] time_entry;
    logic [11:0] temp_entry;
  } out_item_t;

  typedef struct packed {
    logic [6:0] preheat_seconds;
    logic [5:0] quick_start_seconds;
    logic [3:0] buzz_ticks;
  } cfg_t;

  // Controller state; digit 0 is the most significant one entered.
  typedef struct packed {
    phase_e          phase;
    logic [2:0]      mode;
    logic [3:0][3:0] time_digits;
    logic [1:0]      time_pos;
    logic [2:0][3:0] temp_digits;
    logic [1:0]      temp_pos;
    logic [6:0]      minutes;
    logic [6:0]      seconds;
    logic [6:0]      preheat;
    logic [9:0]      temp_value;
    logic [3:0]      buzz;
  } ctrl_state_t;

endpackage

// ----- src/occ_step.sv -----
// Next-state logic of the oven cook controller for one keypad event or tick.
// Purely combinational; uses the types and codes of occ_pkg.
module occ_step (
  input  occ_pkg::ctrl_state_t cur_i,
  input  occ_pkg::cfg_t        cfg_i,
  input  occ_pkg::in_item_t    item_i,
  output occ_pkg::ctrl_state_t nxt_o
);
  import occ_pkg::*;

  logic       tick;
  logic       is_key;
  logic [3:0] key;
  logic [1:0] temp_idx;

  assign tick   = item_i.command;
  assign is_key = ~item_i.command;
  assign key    = item_i.key_code;
  // Temperature digits fill positions 0, 1, 2 and then keep overwriting 2.
  assign temp_idx = (cur_i.temp_pos >= 2'd2) ? 2'd2 : cur_i.temp_pos;

  always_comb begin
    nxt_o = cur_i;
    unique case (cur_i.phase)
      PH_SELECT: begin
        if (is_key && key >= 4'd1 && key <= 4'd4) begin
          nxt_o.mode  = key[2:0];
          nxt_o.phase = PH_POWER;
        end
      end
      // Power display passes on any item.
      PH_POWER: begin
        if (cur_i.mode == MODE_CONV) begin
          nxt_o.phase = PH_SETTEMP;
        end else if (cur_i.mode == MODE_QUICK) begin
          nxt_o.minutes = 7'd0;
          nxt_o.seconds = {1'b0, cfg_i.quick_start_seconds};
          nxt_o.phase   = PH_RUN;
        end else begin
          nxt_o.phase = PH_SETTIME;
        end
      end
      PH_SETTEMP: begin
        if (is_key) begin
          if (key <= KEY_NINE) begin
            nxt_o.temp_digits[temp_idx] = key;
            if (cur_i.temp_pos < 2'd2) nxt_o.temp_pos = cur_i.temp_pos + 2'd1;
          end else if (key == KEY_STAR) begin
            nxt_o.temp_digits = TEMP_CLEARED;
            nxt_o.temp_pos    = 2'd0;
          end else if (key == KEY_HASH) begin
            nxt_o.temp_value = 10'(cur_i.temp_digits[0]) * 10'd100
                             + 10'(cur_i.temp_digits[1]) * 10'd10
                             + 10'(cur_i.temp_digits[2]);
            nxt_o.preheat = (cfg_i.preheat_seconds > PREHEAT_MAX) ? PREHEAT_MAX
                                                                  : cfg_i.preheat_seconds;
            nxt_o.phase = PH_PREHEAT;
          end
        end
      end
      PH_PREHEAT: begin
        if (tick) begin
          if (cur_i.preheat != 7'd0) nxt_o.preheat = cur_i.preheat - 7'd1;
          else nxt_o.phase = PH_SETTIME;
        end
      end
      PH_SETTIME: begin
        if (is_key) begin
          if (key <= KEY_NINE) begin
            nxt_o.time_digits[cur_i.time_pos] = key;
            if (cur_i.time_pos != 2'd3) nxt_o.time_pos = cur_i.time_pos + 2'd1;
          end else if (key == KEY_STAR) begin
            nxt_o.time_digits = '0;
            nxt_o.time_pos    = 2'd0;
          end else if (key == KEY_HASH) begin
            nxt_o.minutes = 7'(cur_i.time_digits[0]) * 7'd10 + 7'(cur_i.time_digits[1]);
            nxt_o.seconds = 7'(cur_i.time_digits[2]) * 7'd10 + 7'(cur_i.time_digits[3]);
            nxt_o.phase   = PH_RUN;
          end
        end
      end
      // Countdown on ticks: seconds first, then borrow a minute; star pauses, zero stops.
      PH_RUN: begin
        if (is_key) begin
          if (key == KEY_STAR) begin
            nxt_o.phase = PH_PAUSE;
          end else if (key == KEY_ZERO) begin
            nxt_o.time_digits = '0;
            nxt_o.time_pos    = 2'd0;
            nxt_o.minutes     = 7'd0;
            nxt_o.seconds     = 7'd0;
            nxt_o.phase       = PH_SELECT;
          end
        end else if (cur_i.seconds != 7'd0) begin
          nxt_o.seconds = cur_i.seconds - 7'd1;
        end else if (cur_i.minutes != 7'd0) begin
          nxt_o.minutes = cur_i.minutes - 7'd1;
          nxt_o.seconds = SECONDS_WRAP;
        end else begin
          nxt_o.phase = (cur_i.mode == MODE_CONV) ? PH_DONE : PH_COMPLETE;
          nxt_o.buzz  = cfg_i.buzz_ticks;
        end
      end
      PH_PAUSE: begin
        if (is_key) begin
          if (key == KEY_HASH) begin
            nxt_o.phase = PH_RUN;
          end else if (key == KEY_ZERO) begin
            nxt_o.time_digits = '0;
            nxt_o.time_pos    = 2'd0;
            nxt_o.minutes     = 7'd0;
            nxt_o.seconds     = 7'd0;
            nxt_o.phase       = PH_SELECT;
          end
        end
      end
      // Buzzer phase: count ticks down, then clear and return to select.
      PH_COMPLETE, PH_DONE: begin
        if (tick) begin
          if (cur_i.buzz <= 4'd1) begin
            nxt_o.buzz        = 4'd0;
            nxt_o.time_digits = '0;
            nxt_o.time_pos    = 2'd0;
            nxt_o.minutes     = 7'd0;
            nxt_o.seconds     = 7'd0;
            if (cur_i.phase == PH_DONE) begin
              nxt_o.temp_digits = TEMP_CLEARED;
              nxt_o.temp_pos    = 2'd0;
            end
            nxt_o.phase = PH_SELECT;
          end else begin
            nxt_o.buzz = cur_i.buzz - 4'd1;
          end
        end
      end
      default: begin
        nxt_o.phase = PH_SELECT;
      end
    endcase
  end

endmodule

// ----- src/oven_cook_controller_core.sv -----
// Top level of the oven cook controller: state, configuration and result register.
// Depends on occ_pkg and on occ_step for the next-state logic.
//
// Usage:
// - Input channel (in_valid_i, in_stall_o, in_data_i) carries one keypad event
//   or one-second tick per transfer. Output channel (out_valid_o, out_stall_i,
//   out_data_o) carries exactly one status item for each input transfer.
// - The state advances on the input transfer; the status item is loaded into
//   the result register at the same edge and is shown on the next cycle.
// - Throughput is one item per cycle while the receiver does not stall: a new
//   item is taken in the same cycle that the previous result is taken. The
//   only limit is the result register.
// - When the receiver stalls with a result pending, in_stall_o rises and the
//   result holds until it is taken.
// - Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the
//   edge; an index past the last register is ignored. Write only while idle.
// - Reset puts the block in mode select, micro mode, preheat 60 s, quick
//   start 30 s, buzzer 5 ticks, and empties the result register.
module oven_cook_controller_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  occ_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output occ_pkg::out_item_t              out_data_o,
  input  logic                            cfg_we_i,
  input  logic [occ_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [occ_pkg::CfgDataW-1:0]    cfg_data_i
);
  import occ_pkg::*;

  ctrl_state_t state_q, state_d;
  cfg_t        cfg_q;
  out_item_t   out_q, out_d;
  logic        out_valid_q;
  logic        in_xfer;

  // The result register frees up when it is empty or its item is taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  occ_step u_step (
    .cur_i  (state_q),
    .cfg_i  (cfg_q),
    .item_i (in_data_i),
    .nxt_o  (state_d)
  );

  // Status item formed from the state after the item is applied.
  always_comb begin
    out_d.phase        = state_d.phase;
    out_d.cook_mode    = state_d.mode;
    out_d.minutes_left = state_d.minutes;
    out_d.seconds_left = state_d.seconds;
    out_d.preheat_left = state_d.preheat;
    out_d.heater_on    = (state_d.phase == PH_RUN) || (state_d.phase == PH_PREHEAT);
    out_d.buzzer_on    = (state_d.phase == PH_COMPLETE) || (state_d.phase == PH_DONE);
    out_d.temp_setting = state_d.temp_value;
    out_d.time_entry   = {state_d.time_digits[0], state_d.time_digits[1],
                          state_d.time_digits[2], state_d.time_digits[3]};
    out_d.temp_entry   = {state_d.temp_digits[0], state_d.temp_digits[1],
                          state_d.temp_digits[2]};
  end

  // Controller state advances on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase       <= PH_SELECT;
      state_q.mode        <= MODE_MICRO;
      state_q.time_digits <= '0;
      state_q.time_pos    <= 2'd0;
      state_q.temp_digits <= TEMP_CLEARED;
      state_q.temp_pos    <= 2'd0;
      state_q.minutes     <= 7'd0;
      state_q.seconds     <= 7'd0;
      state_q.preheat     <= PREHEAT_RESET;
      state_q.temp_value  <= 10'd1;
      state_q.buzz        <= 4'd0;
    end else if (in_xfer) begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preheat_seconds     <= PREHEAT_RESET;
      cfg_q.quick_start_seconds <= QUICK_RESET;
      cfg_q.buzz_ticks          <= BUZZ_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PREHEAT: cfg_q.preheat_seconds     <= cfg_data_i;
        CFG_QUICK:   cfg_q.quick_start_seconds <= cfg_data_i[5:0];
        CFG_BUZZ:    cfg_q.buzz_ticks          <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload loads with each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- dv/oven_cook_controller_core_tb.sv -----
// Self-checking testbench for oven_cook_controller_core: keypad and tick transfers in,
// one status item out per transfer, compared against an in-bench model of the controller.
// Depends on occ_pkg and the controller RTL only.
module oven_cook_controller_core_tb;
  import occ_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED   = 2'd3;
  localparam int                 ROUND_ITEMS  = 200;
  localparam int                 SHOWN_ERRORS = 10;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  // Block inputs, all known from time zero.
  logic                in_valid = 1'b0;
  in_item_t            in_data = '0;
  logic                out_stall = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_stall;
  logic                out_valid;
  out_item_t           out_data;

  oven_cook_controller_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Keypad and tick events waiting to be sent, and the status items they must produce.
  in_item_t  pending_events[$];
  out_item_t status_due[$];

  int sender_gap_pct = 19;
  int receiver_stall_pct = 69;
  int events_sent = 0;
  int status_checked = 0;
  int mismatches = 0;
  int sessions_run = 0;
  int settings_used = 0;

  // Controller model: configuration copy.
  logic [6:0] set_preheat = PREHEAT_RESET;
  logic [5:0] set_quick = QUICK_RESET;
  logic [3:0] set_buzz = BUZZ_RESET;

  // Controller model: state, with digit 0 the first one keyed in.
  phase_e     oven_phase = PH_SELECT;
  logic [2:0] oven_mode = MODE_MICRO;
  logic [3:0] time_dig [4] = '{4'd0, 4'd0, 4'd0, 4'd0};
  logic [1:0] time_pos = 2'd0;
  logic [3:0] temp_dig [3] = '{4'd0, 4'd0, 4'd1};
  logic [1:0] temp_pos = 2'd0;
  logic [6:0] run_min = 7'd0;
  logic [6:0] run_sec = 7'd0;
  logic [6:0] preheat_cnt = 7'd60;
  logic [9:0] temp_val = 10'd1;
  logic [3:0] buzz_cnt = 4'd0;

  function automatic void clear_cook_time();
    for (int i = 0; i < 4; i++) time_dig[i] = 4'd0;
    time_pos = 2'd0;
    run_min = 7'd0;
    run_sec = 7'd0;
  endfunction

  function automatic void clear_temp_entry();
    temp_dig[0] = 4'd0;
    temp_dig[1] = 4'd0;
    temp_dig[2] = 4'd1;
    temp_pos = 2'd0;
  endfunction

  // Applies one event to the model and returns the status the block must report.
  function automatic out_item_t advance_oven(in_item_t ev);
    logic       is_tick;
    logic [3:0] k;
    out_item_t  s;
    is_tick = ev.command;
    k = ev.key_code;
    case (oven_phase)
      PH_SELECT: begin
        if (!is_tick && k >= 4'd1 && k <= 4'd4) begin
          oven_mode = k[2:0];
          oven_phase = PH_POWER;
        end
      end
      PH_POWER: begin
        // Any event closes the power display; its key is otherwise dropped.
        if (oven_mode == MODE_CONV) begin
          oven_phase = PH_SETTEMP;
        end else if (oven_mode == MODE_QUICK) begin
          run_min = 7'd0;
          run_sec = {1'b0, set_quick};
          oven_phase = PH_RUN;
        end else begin
          oven_phase = PH_SETTIME;
        end
      end
      PH_SETTEMP: begin
        if (!is_tick) begin
          if (k <= KEY_NINE) begin
            temp_dig[temp_pos] = k;
            if (temp_pos < 2'd2) temp_pos++;
          end else if (k == KEY_STAR) begin
            clear_temp_entry();
          end else if (k == KEY_HASH) begin
            temp_val = 10'(temp_dig[0] * 100 + temp_dig[1] * 10 + temp_dig[2]);
            preheat_cnt = (set_preheat > PREHEAT_MAX) ? PREHEAT_MAX : set_preheat;
            oven_phase = PH_PREHEAT;
          end
        end
      end
      PH_PREHEAT: begin
        if (is_tick) begin
          if (preheat_cnt != 7'd0) preheat_cnt--;
          else oven_phase = PH_SETTIME;
        end
      end
      PH_SETTIME: begin
        if (!is_tick) begin
          if (k <= KEY_NINE) begin
            time_dig[time_pos] = k;
            if (time_pos < 2'd3) time_pos++;
          end else if (k == KEY_STAR) begin
            for (int i = 0; i < 4; i++) time_dig[i] = 4'd0;
            time_pos = 2'd0;
          end else if (k == KEY_HASH) begin
            run_min = 7'(time_dig[0] * 10 + time_dig[1]);
            run_sec = 7'(time_dig[2] * 10 + time_dig[3]);
            oven_phase = PH_RUN;
          end
        end
      end
      PH_RUN: begin
        if (!is_tick) begin
          if (k == KEY_STAR) begin
            oven_phase = PH_PAUSE;
          end else if (k == KEY_ZERO) begin
            clear_cook_time();
            oven_phase = PH_SELECT;
          end
        end else if (run_sec != 7'd0) begin
          run_sec--;
        end else if (run_min != 7'd0) begin
          run_min--;
          run_sec = SECONDS_WRAP;
        end else begin
          oven_phase = (oven_mode == MODE_CONV) ? PH_DONE : PH_COMPLETE;
          buzz_cnt = set_buzz;
        end
      end
      PH_PAUSE: begin
        if (!is_tick) begin
          if (k == KEY_HASH) begin
            oven_phase = PH_RUN;
          end else if (k == KEY_ZERO) begin
            clear_cook_time();
            oven_phase = PH_SELECT;
          end
        end
      end
      PH_COMPLETE, PH_DONE: begin
        // A buzzer count of zero ends the phase on the first tick, like one.
        if (is_tick) begin
          if (buzz_cnt <= 4'd1) begin
            buzz_cnt = 4'd0;
            clear_cook_time();
            if (oven_phase == PH_DONE) clear_temp_entry();
            oven_phase = PH_SELECT;
          end else begin
            buzz_cnt--;
          end
        end
      end
      default: oven_phase = PH_SELECT;
    endcase
    s.phase = oven_phase;
    s.cook_mode = oven_mode;
    s.minutes_left = run_min;
    s.seconds_left = run_sec;
    s.preheat_left = preheat_cnt;
    s.heater_on = (oven_phase == PH_RUN) || (oven_phase == PH_PREHEAT);
    s.buzzer_on = (oven_phase == PH_COMPLETE) || (oven_phase == PH_DONE);
    s.temp_setting = temp_val;
    s.time_entry = {time_dig[0], time_dig[1], time_dig[2], time_dig[3]};
    s.temp_entry = {temp_dig[0], temp_dig[1], temp_dig[2]};
    return s;
  endfunction

  function automatic bit status_differs(out_item_t a, out_item_t b);
    return a.phase !== b.phase || a.cook_mode !== b.cook_mode ||
           a.minutes_left !== b.minutes_left || a.seconds_left !== b.seconds_left ||
           a.preheat_left !== b.preheat_left || a.heater_on !== b.heater_on ||
           a.buzzer_on !== b.buzzer_on || a.temp_setting !== b.temp_setting ||
           a.time_entry !== b.time_entry || a.temp_entry !== b.temp_entry;
  endfunction

  // Driver: a transfer updates the model; a new event goes out when the slot is free.
  always @(posedge clk or negedge rst_n) begin : event_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        status_due.push_back(advance_oven(in_data));
        events_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= pending_events.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each status transfer is checked against the oldest prediction.
  always @(posedge clk or negedge rst_n) begin : status_monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        status_checked++;
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_ERRORS)
            $display("%0t: status item %h arrived with no event to explain it", $time, out_data);
        end else begin
          want = status_due.pop_front();
          if (status_differs(want, out_data)) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
              $display("%0t: status mismatch (phase mode mm ss pre heat buzz temp time tempd)",
                       $time);
              $display("  expected %0d %0d %0d %0d %0d %b %b %0d %h %h", want.phase,
                       want.cook_mode, want.minutes_left, want.seconds_left, want.preheat_left,
                       want.heater_on, want.buzzer_on, want.temp_setting, want.time_entry,
                       want.temp_entry);
              $display("  actual   %0d %0d %0d %0d %0d %b %b %0d %h %h", out_data.phase,
                       out_data.cook_mode, out_data.minutes_left, out_data.seconds_left,
                       out_data.preheat_left, out_data.heater_on, out_data.buzzer_on,
                       out_data.temp_setting, out_data.time_entry, out_data.temp_entry);
            end
          end
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  task automatic queue_key(input logic [3:0] k);
    in_item_t ev;
    ev.command = 1'b0;
    ev.key_code = k;
    pending_events.push_back(ev);
  endtask

  // Ticks carry a random key field, which the block must ignore.
  task automatic queue_ticks(input int n);
    in_item_t ev;
    repeat (n) begin
      ev.command = 1'b1;
      ev.key_code = 4'($urandom_range(15));
      pending_events.push_back(ev);
    end
  endtask

  task automatic queue_noise();
    in_item_t ev;
    ev.command = 1'($urandom_range(1));
    ev.key_code = 4'($urandom_range(15));
    pending_events.push_back(ev);
  endtask

  // One cooking session from mode select, with random detours, pauses and stops.
  task automatic queue_session();
    int         mode;
    int         n;
    int         pos;
    int         r;
    int         secs;
    int         left;
    logic [3:0] d;
    logic [3:0] entry [4];
    sessions_run++;
    // Now and then a burst of arbitrary events instead of a clean session.
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(3, 10)) queue_noise();
      return;
    end
    mode = $urandom_range(1, 4);
    queue_key(4'(mode));
    queue_noise();
    if (mode == MODE_CONV) begin
      repeat ($urandom_range(0, 4)) queue_key(4'($urandom_range(0, 9)));
      if ($urandom_range(9) == 0) begin
        queue_key(KEY_STAR);
        queue_key(4'($urandom_range(0, 9)));
      end
      queue_key(KEY_HASH);
      left = ((set_preheat > PREHEAT_MAX) ? PREHEAT_MAX : set_preheat) + 1;
      while (left > 0) begin
        if ($urandom_range(9) == 0) begin
          queue_key(4'($urandom_range(15)));
        end else begin
          queue_ticks(1);
          left--;
        end
      end
    end
    if (mode == MODE_QUICK) begin
      secs = set_quick;
    end else begin
      // Time entry, kept short: minutes mostly zero.
      for (int i = 0; i < 4; i++) entry[i] = 4'd0;
      pos = 0;
      if ($urandom_range(7) == 0) begin
        repeat ($urandom_range(1, 4)) queue_key(4'($urandom_range(0, 9)));
        queue_key(KEY_STAR);
      end
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) begin
        case (pos)
          0: d = 4'd0;
          1: d = ($urandom_range(7) == 0) ? 4'($urandom_range(1, 2)) : 4'd0;
          2: d = ($urandom_range(5) == 0) ? 4'($urandom_range(0, 9)) : 4'($urandom_range(0, 2));
          default: d = 4'($urandom_range(0, 9));
        endcase
        entry[pos] = d;
        if (pos < 3) pos++;
        queue_key(d);
      end
      queue_key(KEY_HASH);
      secs = (entry[0] * 10 + entry[1]) * 60 + entry[2] * 10 + entry[3];
    end
    // Countdown, including the tick that finds 00:00.
    left = secs + 1;
    while (left > 0) begin
      r = $urandom_range(99);
      if (r < 1) begin
        queue_key(KEY_ZERO);
        return;
      end else if (r < 6) begin
        queue_key(KEY_STAR);
        repeat ($urandom_range(0, 3)) begin
          if ($urandom_range(1) == 0) begin
            queue_ticks(1);
          end else begin
            d = 4'($urandom_range(1, 14));
            if (d >= KEY_HASH) d++;
            queue_key(d);
          end
        end
        if ($urandom_range(9) == 0) begin
          queue_key(KEY_ZERO);
          return;
        end
        queue_key(KEY_HASH);
      end else if (r < 10) begin
        d = 4'($urandom_range(1, 14));
        if (d >= KEY_STAR) d++;
        queue_key(d);
      end else begin
        queue_ticks(1);
        left--;
      end
    end
    // Buzzer phase: keys are ignored, ticks count down.
    left = (set_buzz == 4'd0) ? 1 : set_buzz;
    while (left > 0) begin
      if ($urandom_range(7) == 0) begin
        queue_key(4'($urandom_range(15)));
      end else begin
        queue_ticks(1);
        left--;
      end
    end
  endtask

  // Register write at one edge; the model copy follows the same write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_PREHEAT: set_preheat = data;
      CFG_QUICK:   set_quick = data[5:0];
      CFG_BUZZ:    set_buzz = data[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every event is sent and every status item has come back.
  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_events.size() != 0 || in_valid || status_due.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: short settings so every phase is reached quickly.
    write_reg(CFG_PREHEAT, 7'd1);
    write_reg(CFG_QUICK, 7'd0);
    write_reg(CFG_BUZZ, 7'd0);
    settings_used++;
    @(negedge clk);
    queue_ticks(1);                         // tick in mode select
    queue_key(4'd13);                       // unused key code
    queue_key(4'(MODE_QUICK));
    queue_ticks(3);                         // power ends on a tick, zero-length run, buzz of 0
    queue_key(4'(MODE_CONV));
    queue_key(4'd7);                        // closes the power display, digit dropped
    queue_key(4'd9);
    queue_key(4'd9);
    queue_key(4'd9);
    queue_key(4'd8);                        // full temperature entry, last digit overwritten
    queue_key(KEY_HASH);
    queue_ticks(2);                         // preheat 1 -> 0, then the tick at zero
    repeat (5) queue_key(KEY_NINE);         // 99:99 with an overwrite
    queue_key(KEY_HASH);
    queue_key(KEY_STAR);
    queue_ticks(1);                         // tick while paused
    queue_key(KEY_HASH);
    queue_key(KEY_ZERO);                    // stop
    wait_for_idle();

    // Random rounds over several settings and idle regimes.
    for (int r = 1; r <= 5; r++) begin
      case (r)
        1: begin
          write_reg(CFG_PREHEAT, PREHEAT_RESET);
          write_reg(CFG_QUICK, 7'(QUICK_RESET));
          write_reg(CFG_BUZZ, 7'(BUZZ_RESET));
        end
        2: begin
          write_reg(CFG_PREHEAT, 7'd0);
          write_reg(CFG_QUICK, 7'd59);
          write_reg(CFG_BUZZ, 7'h6F);
          write_reg(CFG_UNUSED, 7'($urandom_range(127)));
        end
        3: begin
          sender_gap_pct = 69;
          receiver_stall_pct = 19;
          write_reg(CFG_PREHEAT, 7'd127);
          write_reg(CFG_QUICK, 7'h7F);
          write_reg(CFG_BUZZ, 7'd1);
        end
        4: begin
          write_reg(CFG_PREHEAT, 7'd2);
          write_reg(CFG_QUICK, 7'd45);
          write_reg(CFG_BUZZ, 7'd3);
        end
        default: begin
          sender_gap_pct = 0;
          receiver_stall_pct = 0;
          write_reg(CFG_PREHEAT, 7'd99);
          write_reg(CFG_QUICK, 7'd12);
          write_reg(CFG_BUZZ, 7'd9);
        end
      endcase
      settings_used++;
      @(negedge clk);
      while (pending_events.size() < ROUND_ITEMS) queue_session();
      wait_for_idle();
    end

    // A prediction still waiting here is a missing status item.
    if (status_due.size() != 0) mismatches += status_due.size();
    $display("Covered %0d register settings and %0d random cooking sessions.",
             settings_used, sessions_run);
    $display("Sent %0d keypad and tick events, checked %0d status items, %0d mismatches.",
             events_sent, status_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
